/* src/atci_pkg.sv */
// ----------------------------------------------------------------------------
// atci_pkg
// Shared constants for the ATA taskfile command issuer: field widths, register
// offsets, opcodes, the CHS reciprocal and the step numbers of the sequence.
// ----------------------------------------------------------------------------
package atci_pkg;

    localparam int unsigned LBA_W   = 32;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned PORT_W  = 4;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned STEP_W  = 5;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;

    // default mode limits
    localparam int unsigned DEF_MAX_SECTORS_LBA28 = 256;
    localparam int unsigned DEF_MAX_SECTORS_LBA48 = 65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LBA_CAP_MASTER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LBA_CAP_SLAVE  = 8'd1;

    // taskfile register offsets
    localparam logic [PORT_W-1:0] PORT_COUNT   = 4'd2;
    localparam logic [PORT_W-1:0] PORT_LBA_LO  = 4'd3;
    localparam logic [PORT_W-1:0] PORT_LBA_MID = 4'd4;
    localparam logic [PORT_W-1:0] PORT_LBA_HI  = 4'd5;
    localparam logic [PORT_W-1:0] PORT_DEVICE  = 4'd6;
    localparam logic [PORT_W-1:0] PORT_COMMAND = 4'd7;
    localparam logic [PORT_W-1:0] PORT_CONTROL = 4'd8;

    // register values
    localparam logic [DATA_W-1:0] DEV_LBA      = 8'hE0;
    localparam logic [DATA_W-1:0] DEV_CHS      = 8'hA0;
    localparam logic [DATA_W-1:0] CTL_HOB      = 8'h80;
    localparam logic [DATA_W-1:0] CTL_CLEAR    = 8'h00;
    localparam logic [DATA_W-1:0] CMD_READ     = 8'h20;
    localparam logic [DATA_W-1:0] CMD_WRITE    = 8'h30;
    localparam logic [DATA_W-1:0] CMD_READ_EXT = 8'h24;
    localparam logic [DATA_W-1:0] CMD_WRITE_EXT = 8'h34;

    // chs: q = floor(x / 63) = (x * CHS_RECIP) >> CHS_SHIFT for x < 2^28
    localparam int unsigned CHS_IN_W   = 28;
    localparam int unsigned CHS_Q_W    = 22;
    localparam int unsigned CHS_RECIP_W = 29;
    localparam int unsigned CHS_SHIFT  = 34;
    localparam logic [CHS_RECIP_W-1:0] CHS_RECIP = 29'd272696337;
    localparam int unsigned CHS_PROD_W = CHS_IN_W + CHS_RECIP_W;

    // step numbers of the write sequence
    localparam logic [STEP_W-1:0] ST_DEV       = 5'd0;
    localparam logic [STEP_W-1:0] ST_CTL       = 5'd1;
    localparam logic [STEP_W-1:0] ST_H3_SET    = 5'd2;
    localparam logic [STEP_W-1:0] ST_H3_BYTE   = 5'd3;
    localparam logic [STEP_W-1:0] ST_H3_CLR    = 5'd4;
    localparam logic [STEP_W-1:0] ST_H4_SET    = 5'd5;
    localparam logic [STEP_W-1:0] ST_H4_BYTE   = 5'd6;
    localparam logic [STEP_W-1:0] ST_H4_CLR    = 5'd7;
    localparam logic [STEP_W-1:0] ST_H5_SET    = 5'd8;
    localparam logic [STEP_W-1:0] ST_H5_BYTE   = 5'd9;
    localparam logic [STEP_W-1:0] ST_H5_CLR    = 5'd10;
    localparam logic [STEP_W-1:0] ST_LBA0      = 5'd11;
    localparam logic [STEP_W-1:0] ST_LBA1      = 5'd12;
    localparam logic [STEP_W-1:0] ST_LBA2      = 5'd13;
    localparam logic [STEP_W-1:0] ST_HC_SET    = 5'd14;
    localparam logic [STEP_W-1:0] ST_HC_BYTE   = 5'd15;
    localparam logic [STEP_W-1:0] ST_HC_CLR    = 5'd16;
    localparam logic [STEP_W-1:0] ST_COUNT     = 5'd17;
    localparam logic [STEP_W-1:0] ST_CMD       = 5'd18;

endpackage

/* src/ata_taskfile_command_issuer.sv */
// ----------------------------------------------------------------------------
// ata_taskfile_command_issuer
// Turns one sector request into the ordered ATA taskfile register writes.
// ----------------------------------------------------------------------------
// Each request gives one register write per cycle while the receiver does not
// stall: 7 words in LBA28 or CHS mode, 19 in LBA48 mode, issued by the
// one-word-per-cycle write sequencer, which takes the next request as it issues
// the last word. A request passes an input register and a stage holding the
// CHS divide-by-63 product before it reaches the sequencer, and each word then
// passes an output register; the next request is taken in while the current
// one is still being issued. LBA48 is used for start sectors at or above 2^28,
// LBA28 for LBA-capable drives, CHS (63 sectors, 16 heads) otherwise.
// ----------------------------------------------------------------------------
module ata_taskfile_command_issuer #(
    parameter int unsigned MAX_SECTORS_LBA28 = atci_pkg::DEF_MAX_SECTORS_LBA28,
    parameter int unsigned MAX_SECTORS_LBA48 = atci_pkg::DEF_MAX_SECTORS_LBA48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [atci_pkg::LBA_W-1:0]         i_start_sector,
    input  logic                               i_drive_select,
    input  logic                               i_is_write,
    input  logic [atci_pkg::COUNT_W-1:0]       i_sector_count,
    // register write channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [atci_pkg::PORT_W-1:0]        o_reg_port,
    output logic [atci_pkg::DATA_W-1:0]        o_reg_data,
    output logic [atci_pkg::COUNT_W-1:0]       o_granted_sectors,
    output logic                               o_last,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [atci_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [atci_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic [atci_pkg::COUNT_W-1:0] LIMIT28 = atci_pkg::COUNT_W'(MAX_SECTORS_LBA28);
    localparam logic [atci_pkg::COUNT_W-1:0] LIMIT48 = atci_pkg::COUNT_W'(MAX_SECTORS_LBA48);

    // configuration
    logic r_cap_master;
    logic r_cap_slave;

    // input stage
    logic                         r_s1_valid;
    logic [atci_pkg::LBA_W-1:0]   r_s1_lba;
    logic                         r_s1_slave;
    logic                         r_s1_wr;
    logic [atci_pkg::COUNT_W-1:0] r_s1_count;

    // divide stage
    logic                          r_s2_valid;
    logic [atci_pkg::LBA_W-1:0]    r_s2_lba;
    logic                          r_s2_slave;
    logic                          r_s2_wr;
    logic                          r_s2_cap;
    logic [atci_pkg::COUNT_W-1:0]  r_s2_count;
    logic [atci_pkg::CHS_Q_W-1:0]  r_s2_q;

    // sequencer stage
    logic                          r_s3_valid;
    logic [atci_pkg::STEP_W-1:0]   r_s3_step;
    logic                          r_s3_ext;
    logic [atci_pkg::DATA_W-1:0]   r_s3_dev;
    logic [atci_pkg::DATA_W-1:0]   r_s3_cmd;
    logic [atci_pkg::DATA_W-1:0]   r_s3_b0;
    logic [atci_pkg::DATA_W-1:0]   r_s3_b1;
    logic [atci_pkg::DATA_W-1:0]   r_s3_b2;
    logic [atci_pkg::DATA_W-1:0]   r_s3_b3;
    logic [atci_pkg::COUNT_W-1:0]  r_s3_count;

    // output register
    logic                          r_out_valid;
    logic [atci_pkg::PORT_W-1:0]   r_out_port;
    logic [atci_pkg::DATA_W-1:0]   r_out_data;
    logic [atci_pkg::COUNT_W-1:0]  r_out_count;
    logic                          r_out_last;

    logic out_free, emit, step_last, s3_free, s2_free, s1_free, in_accept;
    logic [atci_pkg::STEP_W-1:0]   n_step;
    logic [atci_pkg::PORT_W-1:0]   n_port;
    logic [atci_pkg::DATA_W-1:0]   n_data;

    logic [atci_pkg::CHS_PROD_W-1:0] prod;
    logic                          s1_cap;

    logic                          s2_ext;
    logic [atci_pkg::CHS_IN_W-1:0] q63;
    logic [atci_pkg::CHS_IN_W-1:0] rem;
    logic [atci_pkg::DATA_W-1:0]   sect;
    logic [15:0]                   cyl;
    logic [3:0]                    head;
    logic [atci_pkg::COUNT_W-1:0]  granted;
    logic [atci_pkg::DATA_W-1:0]   n_dev;
    logic [atci_pkg::DATA_W-1:0]   n_cmd;
    logic [atci_pkg::DATA_W-1:0]   n_b0, n_b1, n_b2;

    // ---------------- handshake ----------------
    assign out_free  = !r_out_valid || !i_stall;
    assign emit      = r_s3_valid && out_free;
    assign step_last = (r_s3_step == atci_pkg::ST_CMD);
    assign s3_free   = !r_s3_valid || (emit && step_last);
    assign s2_free   = !r_s2_valid || s3_free;
    assign s1_free   = !r_s1_valid || s2_free;
    assign in_accept = i_valid && s1_free;
    assign o_stall   = !s1_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_master <= 1'b1;
            r_cap_slave  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                atci_pkg::CFG_LBA_CAP_MASTER: r_cap_master <= i_cfg_data[0];
                atci_pkg::CFG_LBA_CAP_SLAVE:  r_cap_slave  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- input stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_lba   <= i_start_sector;
            r_s1_slave <= i_drive_select;
            r_s1_wr    <= i_is_write;
            r_s1_count <= i_sector_count;
        end
    end

    // ---------------- divide by 63 ----------------
    assign prod   = atci_pkg::CHS_PROD_W'(r_s1_lba[atci_pkg::CHS_IN_W-1:0])
                  * atci_pkg::CHS_PROD_W'(atci_pkg::CHS_RECIP);
    assign s1_cap = r_s1_slave ? r_cap_slave : r_cap_master;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            r_s2_lba   <= r_s1_lba;
            r_s2_slave <= r_s1_slave;
            r_s2_wr    <= r_s1_wr;
            r_s2_cap   <= s1_cap;
            r_s2_count <= r_s1_count;
            r_s2_q     <= prod[atci_pkg::CHS_SHIFT +: atci_pkg::CHS_Q_W];
        end
    end

    // ---------------- decode into taskfile bytes ----------------
    assign s2_ext = (r_s2_lba[atci_pkg::LBA_W-1:atci_pkg::CHS_IN_W] != '0);
    // q * 63 as a shift and subtract
    assign q63    = {r_s2_q, 6'd0} - atci_pkg::CHS_IN_W'(r_s2_q);
    assign rem    = r_s2_lba[atci_pkg::CHS_IN_W-1:0] - q63;
    assign sect   = {2'b00, rem[5:0]} + 8'd1;
    assign cyl    = r_s2_q[19:4];

    always_comb begin
        if (s2_ext) begin
            head    = 4'd0;
            granted = (r_s2_count > LIMIT48) ? LIMIT48 : r_s2_count;
            n_cmd   = r_s2_wr ? atci_pkg::CMD_WRITE_EXT : atci_pkg::CMD_READ_EXT;
        end else begin
            head    = r_s2_cap ? r_s2_lba[27:24] : r_s2_q[3:0];
            granted = (r_s2_count > LIMIT28) ? LIMIT28 : r_s2_count;
            n_cmd   = r_s2_wr ? atci_pkg::CMD_WRITE : atci_pkg::CMD_READ;
        end
        if (s2_ext || r_s2_cap) begin
            n_b0 = r_s2_lba[7:0];
            n_b1 = r_s2_lba[15:8];
            n_b2 = r_s2_lba[23:16];
        end else begin
            n_b0 = sect;
            n_b1 = cyl[7:0];
            n_b2 = cyl[15:8];
        end
        n_dev = (r_s2_cap ? atci_pkg::DEV_LBA : atci_pkg::DEV_CHS)
              | {3'b000, r_s2_slave, head};
    end

    // ---------------- sequencer ----------------
    always_comb begin
        if (!r_s3_ext && r_s3_step == atci_pkg::ST_CTL) begin
            n_step = atci_pkg::ST_LBA0;
        end else if (!r_s3_ext && r_s3_step == atci_pkg::ST_LBA2) begin
            n_step = atci_pkg::ST_COUNT;
        end else begin
            n_step = r_s3_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s3_step  <= atci_pkg::ST_DEV;
        end else if (s3_free) begin
            r_s3_valid <= r_s2_valid;
            r_s3_step  <= atci_pkg::ST_DEV;
        end else if (emit) begin
            r_s3_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free && r_s2_valid) begin
            r_s3_ext   <= s2_ext;
            r_s3_dev   <= n_dev;
            r_s3_cmd   <= n_cmd;
            r_s3_b0    <= n_b0;
            r_s3_b1    <= n_b1;
            r_s3_b2    <= n_b2;
            r_s3_b3    <= r_s2_lba[31:24];
            r_s3_count <= granted;
        end
    end

    always_comb begin
        unique case (r_s3_step)
            atci_pkg::ST_DEV: begin
                n_port = atci_pkg::PORT_DEVICE;  n_data = r_s3_dev;
            end
            atci_pkg::ST_CTL, atci_pkg::ST_H3_CLR, atci_pkg::ST_H4_CLR,
            atci_pkg::ST_H5_CLR, atci_pkg::ST_HC_CLR: begin
                n_port = atci_pkg::PORT_CONTROL; n_data = atci_pkg::CTL_CLEAR;
            end
            atci_pkg::ST_H3_SET, atci_pkg::ST_H4_SET, atci_pkg::ST_H5_SET,
            atci_pkg::ST_HC_SET: begin
                n_port = atci_pkg::PORT_CONTROL; n_data = atci_pkg::CTL_HOB;
            end
            atci_pkg::ST_H3_BYTE: begin
                n_port = atci_pkg::PORT_LBA_LO;  n_data = r_s3_b3;
            end
            atci_pkg::ST_H4_BYTE: begin
                n_port = atci_pkg::PORT_LBA_MID; n_data = '0;
            end
            atci_pkg::ST_H5_BYTE: begin
                n_port = atci_pkg::PORT_LBA_HI;  n_data = '0;
            end
            atci_pkg::ST_LBA0: begin
                n_port = atci_pkg::PORT_LBA_LO;  n_data = r_s3_b0;
            end
            atci_pkg::ST_LBA1: begin
                n_port = atci_pkg::PORT_LBA_MID; n_data = r_s3_b1;
            end
            atci_pkg::ST_LBA2: begin
                n_port = atci_pkg::PORT_LBA_HI;  n_data = r_s3_b2;
            end
            atci_pkg::ST_HC_BYTE: begin
                n_port = atci_pkg::PORT_COUNT;   n_data = r_s3_count[15:8];
            end
            atci_pkg::ST_COUNT: begin
                n_port = atci_pkg::PORT_COUNT;   n_data = r_s3_count[7:0];
            end
            atci_pkg::ST_CMD: begin
                n_port = atci_pkg::PORT_COMMAND; n_data = r_s3_cmd;
            end
            default: begin
                n_port = atci_pkg::PORT_CONTROL; n_data = atci_pkg::CTL_CLEAR;
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_port  <= n_port;
            r_out_data  <= n_data;
            r_out_count <= r_s3_count;
            r_out_last  <= step_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_reg_port        = r_out_port;
    assign o_reg_data        = r_out_data;
    assign o_granted_sectors = r_out_count;
    assign o_last            = r_out_last;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ATA taskfile command issuer. Sector requests are
// sent in directed and random bursts under several drive-capability settings;
// a predictor builds the expected register write sequence per request and a
// checker compares each word taken from the block, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [atci_pkg::LBA_W-1:0]   start;
        logic                         slave;
        logic                         wr;
        logic [atci_pkg::COUNT_W-1:0] count;
    } t_request;

    typedef struct packed {
        logic [atci_pkg::PORT_W-1:0]  port;
        logic [atci_pkg::DATA_W-1:0]  data;
        logic [atci_pkg::COUNT_W-1:0] granted;
        logic                         last;
    } t_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [atci_pkg::LBA_W-1:0]      i_start_sector = '0;
    logic                            i_drive_select = 1'b0;
    logic                            i_is_write = 1'b0;
    logic [atci_pkg::COUNT_W-1:0]    i_sector_count = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [atci_pkg::PORT_W-1:0]     o_reg_port;
    logic [atci_pkg::DATA_W-1:0]     o_reg_data;
    logic [atci_pkg::COUNT_W-1:0]    o_granted_sectors;
    logic                            o_last;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [atci_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [atci_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // local copy of the capability registers
    logic cap_master = 1'b1;
    logic cap_slave  = 1'b1;

    t_word taskfile_q[$];
    int    n_mismatch = 0;

    // receiver stall control
    logic        rx_jitter = 1'b0;
    int unsigned hold_left = 0;
    int unsigned run_left = 0;

    ata_taskfile_command_issuer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_start_sector    (i_start_sector),
        .i_drive_select    (i_drive_select),
        .i_is_write        (i_is_write),
        .i_sector_count    (i_sector_count),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_reg_port        (o_reg_port),
        .o_reg_data        (o_reg_data),
        .o_granted_sectors (o_granted_sectors),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic void push_word(input logic [atci_pkg::PORT_W-1:0] port,
                                      input logic [atci_pkg::DATA_W-1:0] data,
                                      input logic [atci_pkg::COUNT_W-1:0] granted,
                                      input logic last);
        t_word w;
        w.port    = port;
        w.data    = data;
        w.granted = granted;
        w.last    = last;
        taskfile_q.push_back(w);
    endfunction

    // high-order byte framed by hob set and clear on device control
    function automatic void push_hob(input logic [atci_pkg::PORT_W-1:0] port,
                                     input logic [atci_pkg::DATA_W-1:0] data,
                                     input logic [atci_pkg::COUNT_W-1:0] granted);
        push_word(atci_pkg::PORT_CONTROL, atci_pkg::CTL_HOB, granted, 1'b0);
        push_word(port, data, granted, 1'b0);
        push_word(atci_pkg::PORT_CONTROL, atci_pkg::CTL_CLEAR, granted, 1'b0);
    endfunction

    function automatic void predict_taskfile(input t_request r);
        logic                         cap;
        logic                         ext;
        logic [31:0]                  track;
        logic [15:0]                  cyl;
        logic [3:0]                   head;
        logic [atci_pkg::DATA_W-1:0]  b0, b1, b2, dev, cmd;
        logic [atci_pkg::COUNT_W-1:0] granted;
        cap = r.slave ? cap_slave : cap_master;
        ext = r.start >= 32'h1000_0000;
        if (ext || cap) begin
            b0   = r.start[7:0];
            b1   = r.start[15:8];
            b2   = r.start[23:16];
            head = ext ? 4'd0 : r.start[27:24];
        end else begin
            // chs geometry: 63 sectors per track, 16 heads
            track = r.start / 63;
            cyl   = 16'(track / 16);
            b0    = 8'(r.start % 63 + 1);
            b1    = cyl[7:0];
            b2    = cyl[15:8];
            head  = track[3:0];
        end
        if (ext)
            granted = (r.count > atci_pkg::DEF_MAX_SECTORS_LBA48) ?
                      atci_pkg::COUNT_W'(atci_pkg::DEF_MAX_SECTORS_LBA48) : r.count;
        else
            granted = (r.count > atci_pkg::DEF_MAX_SECTORS_LBA28) ?
                      atci_pkg::COUNT_W'(atci_pkg::DEF_MAX_SECTORS_LBA28) : r.count;
        if (ext)
            cmd = r.wr ? atci_pkg::CMD_WRITE_EXT : atci_pkg::CMD_READ_EXT;
        else
            cmd = r.wr ? atci_pkg::CMD_WRITE : atci_pkg::CMD_READ;
        dev = (cap ? atci_pkg::DEV_LBA : atci_pkg::DEV_CHS) | {3'b000, r.slave, head};

        push_word(atci_pkg::PORT_DEVICE, dev, granted, 1'b0);
        push_word(atci_pkg::PORT_CONTROL, atci_pkg::CTL_CLEAR, granted, 1'b0);
        if (ext) begin
            push_hob(atci_pkg::PORT_LBA_LO, r.start[31:24], granted);
            push_hob(atci_pkg::PORT_LBA_MID, 8'h00, granted);
            push_hob(atci_pkg::PORT_LBA_HI, 8'h00, granted);
        end
        push_word(atci_pkg::PORT_LBA_LO, b0, granted, 1'b0);
        push_word(atci_pkg::PORT_LBA_MID, b1, granted, 1'b0);
        push_word(atci_pkg::PORT_LBA_HI, b2, granted, 1'b0);
        if (ext)
            push_hob(atci_pkg::PORT_COUNT, granted[15:8], granted);
        push_word(atci_pkg::PORT_COUNT, granted[7:0], granted, 1'b0);
        push_word(atci_pkg::PORT_COMMAND, cmd, granted, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (n_mismatch < 40)
            $display("mismatch at %0t: %s", $realtime, msg);
        n_mismatch++;
    endtask

    // outputs settle by the falling edge, the word moves at the next rise
    always @(negedge i_clk) begin : chk
        t_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (taskfile_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word port %0d data %02h",
                                          o_reg_port, o_reg_data));
            end else begin
                want = taskfile_q.pop_front();
                if (o_reg_port !== want.port)
                    report_mismatch($sformatf("reg_port %0d, wanted %0d",
                                              o_reg_port, want.port));
                if (o_reg_data !== want.data)
                    report_mismatch($sformatf("reg_data %02h, wanted %02h (port %0d)",
                                              o_reg_data, want.data, want.port));
                if (o_granted_sectors !== want.granted)
                    report_mismatch($sformatf("granted_sectors %0d, wanted %0d",
                                              o_granted_sectors, want.granted));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, wanted %0b (port %0d)",
                                              o_last, want.last, want.port));
            end
        end
    end

    // receiver: runs of stall and no stall, or a long counted hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!rx_jitter) begin
            i_stall <= 1'b0;
        end else if (run_left == 0) begin
            i_stall  <= ($urandom_range(0, 2) == 0);
            run_left <= $urandom_range(0, 12);
        end else begin
            run_left <= run_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_request(input logic [atci_pkg::LBA_W-1:0] start,
                                input logic slave, input logic wr,
                                input logic [atci_pkg::COUNT_W-1:0] count);
        t_request r;
        r = '{start: start, slave: slave, wr: wr, count: count};
        i_valid        <= 1'b1;
        i_start_sector <= start;
        i_drive_select <= slave;
        i_is_write     <= wr;
        i_sector_count <= count;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        predict_taskfile(r);
    endtask

    task automatic pause_sender(input int unsigned n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (taskfile_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [atci_pkg::CFG_IDX_W-1:0] idx,
                             input logic [atci_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == atci_pkg::CFG_LBA_CAP_MASTER)
            cap_master = val[0];
        else if (idx == atci_pkg::CFG_LBA_CAP_SLAVE)
            cap_slave = val[0];
        @(posedge i_clk);
    endtask

    function automatic logic [atci_pkg::LBA_W-1:0] pick_sector();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0FFF_FFFF);
            2: return $urandom_range(0, 5000);
            3: return 32'h0FFF_FFF0 + $urandom_range(0, 31);
            4: return $urandom_range(32'h1000_0000, 32'hFFFF_FFFE);
            default: return 32'd66060288 - 2000 + $urandom_range(0, 4000);
        endcase
    endfunction

    function automatic logic [atci_pkg::COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return atci_pkg::COUNT_W'($urandom_range(1, 256));
            2: return atci_pkg::COUNT_W'($urandom_range(255, 258));
            3: return atci_pkg::COUNT_W'($urandom_range(0, 131071));
            4: return atci_pkg::COUNT_W'($urandom_range(65534, 65538));
            default: return atci_pkg::COUNT_W'($urandom_range(1, 20));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // both drives lba capable after reset
    task automatic test_lba_modes();
        send_request(32'h0000_0000, 1'b0, 1'b0, 17'd0);
        send_request(32'h0FFF_FFFF, 1'b1, 1'b1, 17'd256);
        send_request(32'h0ABC_DEF1, 1'b0, 1'b1, 17'd257);
        send_request(32'h1000_0000, 1'b0, 1'b0, 17'd65536);
        send_request(32'hFFFF_FFFF, 1'b1, 1'b1, 17'd131071);
        send_request(32'h1234_5678, 1'b1, 1'b0, 17'd0);
        send_request(32'h8765_4321, 1'b0, 1'b1, 17'd65535);
        send_request(32'h0000_00FF, 1'b0, 1'b0, 17'd1);
        wait_drain();
    endtask

    task automatic test_chs_mode();
        write_reg(atci_pkg::CFG_LBA_CAP_MASTER, 8'hFE);
        write_reg(atci_pkg::CFG_LBA_CAP_SLAVE, 8'h00);
        send_request(32'd0, 1'b0, 1'b0, 17'd1);
        send_request(32'd62, 1'b1, 1'b1, 17'd255);
        send_request(32'd63, 1'b0, 1'b0, 17'd256);
        send_request(32'd1007, 1'b1, 1'b1, 17'd300);
        send_request(32'd1008, 1'b0, 1'b0, 17'd0);
        // cylinder past 16 bits
        send_request(32'h0FFF_FFFF, 1'b1, 1'b0, 17'd7);
        send_request(32'd66060288, 1'b0, 1'b1, 17'd2);
        // lba48 on a drive without lba keeps the chs device byte
        send_request(32'h1000_0000, 1'b1, 1'b1, 17'd65537);
        wait_drain();
    endtask

    task automatic test_cfg_index_ignored();
        write_reg(8'd2, 8'hFF);
        write_reg(8'd255, 8'hFF);
        send_request(32'h00AB_CDEF, 1'b0, 1'b0, 17'd10);
        send_request(32'd5, 1'b1, 1'b1, 17'd0);
        wait_drain();
        write_reg(atci_pkg::CFG_LBA_CAP_MASTER, 8'h01);
        send_request(32'h0123_4567, 1'b0, 1'b0, 17'd12);
        send_request(32'h0123_4567, 1'b1, 1'b1, 17'd12);
        wait_drain();
    endtask

    // receiver holds off while requests keep coming, so the input backs up
    task automatic test_backpressure();
        rx_jitter <= 1'b0;
        hold_left <= 300;
        for (int n = 0; n < 14; n++)
            send_request(pick_sector(), 1'($urandom), 1'($urandom), pick_count());
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int unsigned burst;
        burst = 0;
        for (int ph = 0; ph < 4; ph++) begin
            wait_drain();
            rx_jitter <= (ph != 3);
            case (ph)
                0: begin
                    write_reg(atci_pkg::CFG_LBA_CAP_MASTER, {7'($urandom), 1'b1});
                    write_reg(atci_pkg::CFG_LBA_CAP_SLAVE, {7'($urandom), 1'b0});
                end
                1: begin
                    write_reg(atci_pkg::CFG_LBA_CAP_MASTER, {7'($urandom), 1'b0});
                    write_reg(atci_pkg::CFG_LBA_CAP_SLAVE, {7'($urandom), 1'b1});
                end
                2: begin
                    write_reg(atci_pkg::CFG_LBA_CAP_MASTER, 8'($urandom));
                    write_reg(atci_pkg::CFG_LBA_CAP_SLAVE, 8'($urandom));
                end
                default: begin
                    write_reg(atci_pkg::CFG_LBA_CAP_MASTER, 8'hFF);
                    write_reg(atci_pkg::CFG_LBA_CAP_SLAVE, 8'h01);
                end
            endcase
            write_reg(8'($urandom_range(2, 255)), 8'($urandom));
            for (int n = 0; n < 82; n++) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 12);
                    pause_sender($urandom_range(0, 6));
                end
                burst--;
                if ($urandom_range(0, 99) == 0)
                    wait_drain();
                send_request(pick_sector(), 1'($urandom), 1'($urandom), pick_count());
            end
        end
        wait_drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_lba_modes();
        test_chs_mode();
        test_cfg_index_ignored();
        test_backpressure();
        test_random_traffic();
        if (n_mismatch == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
src/atci_pkg.sv
src/ata_taskfile_command_issuer.sv
sim/tb_top.sv
